@@ hw/rtl/bcs_pkg.sv @@
// package for the box containment suppress block
// holds field widths, word structs, controller states and command/status structs
// depends on nothing
`default_nettype none
package bcs_pkg;

   localparam int COORD_BITS = 12;
   localparam int MAX_BOXES  = 64;
   localparam int THR_BITS   = 9;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam logic [THR_BITS-1:0] THR_RESET = 9'd192;

   // register index of the merge threshold
   localparam logic REG_MERGE_THRESHOLD = 1'b0;

   typedef struct packed {
      logic [COORD_BITS-1:0] box_x;
      logic [COORD_BITS-1:0] box_y;
      logic [COORD_BITS-1:0] box_width;
      logic [COORD_BITS-1:0] box_height;
      logic                  last_box;
   } box_in_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] kept_x;
      logic [COORD_BITS-1:0] kept_y;
      logic [COORD_BITS-1:0] kept_width;
      logic [COORD_BITS-1:0] kept_height;
      logic                  last_kept;
   } box_out_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_OUTER,
      ST_INNER,
      ST_WAIT,
      ST_SCAN,
      ST_EMIT,
      ST_EOUT,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic load;
      logic i_clr;
      logic i_inc;
      logic j_from_i;
      logic j_inc;
      logic pair_go;
      logic merge_i;
      logic merge_j;
      logic note_last;
      logic emit;
      logic clear_set;
   } cmd_type;

   typedef struct packed {
      logic i_end;
      logic i_merged;
      logic j_end;
      logic j_merged;
      logic pair_done;
      logic hit;
      logic i_wins;
   } status_type;

endpackage
`default_nettype wire

@@ hw/rtl/bcs_ctrl.sv @@
// controller state machine for box containment suppress
// sequences load, pairwise pass, survivor scan and output
// depends on bcs_pkg
`default_nettype none
module bcs_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic                last_box,
   input  wire bcs_pkg::status_type status,
   output logic                     busy,
   output bcs_pkg::cmd_type         cmd
);

   bcs_pkg::state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bcs_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b1;
      unique case (state_ff)
         bcs_pkg::ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               if (last_box) begin
                  cmd.i_clr = 1'b1;
                  state_in  = bcs_pkg::ST_OUTER;
               end
            end
         end
         bcs_pkg::ST_OUTER: begin
            if (status.i_end) begin
               cmd.i_clr = 1'b1;
               state_in  = bcs_pkg::ST_SCAN;
            end else if (status.i_merged) begin
               cmd.i_inc = 1'b1;
            end else begin
               cmd.j_from_i = 1'b1;
               state_in     = bcs_pkg::ST_INNER;
            end
         end
         bcs_pkg::ST_INNER: begin
            if (status.j_end) begin
               cmd.i_inc = 1'b1;
               state_in  = bcs_pkg::ST_OUTER;
            end else if (status.j_merged) begin
               cmd.j_inc = 1'b1;
            end else begin
               cmd.pair_go = 1'b1;
               state_in    = bcs_pkg::ST_WAIT;
            end
         end
         bcs_pkg::ST_WAIT: begin
            if (status.pair_done) begin
               if (status.hit && !status.i_wins) begin
                  cmd.merge_i = 1'b1;
                  cmd.i_inc   = 1'b1;
                  state_in    = bcs_pkg::ST_OUTER;
               end else begin
                  cmd.merge_j = status.hit;
                  cmd.j_inc   = 1'b1;
                  state_in    = bcs_pkg::ST_INNER;
               end
            end
         end
         bcs_pkg::ST_SCAN: begin
            // find the index of the last survivor
            if (status.i_end) begin
               cmd.i_clr = 1'b1;
               state_in  = bcs_pkg::ST_EMIT;
            end else begin
               cmd.note_last = !status.i_merged;
               cmd.i_inc     = 1'b1;
            end
         end
         bcs_pkg::ST_EMIT: begin
            if (status.i_end) begin
               state_in = bcs_pkg::ST_FINISH;
            end else if (status.i_merged) begin
               cmd.i_inc = 1'b1;
            end else begin
               state_in = bcs_pkg::ST_EOUT;
            end
         end
         bcs_pkg::ST_EOUT: begin
            cmd.emit  = 1'b1;
            cmd.i_inc = 1'b1;
            state_in  = bcs_pkg::ST_EMIT;
         end
         bcs_pkg::ST_FINISH: begin
            cmd.clear_set = 1'b1;
            state_in      = bcs_pkg::ST_IDLE;
         end
         default: begin
            state_in = bcs_pkg::ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

@@ hw/rtl/bcs_dp.sv @@
// datapath for box containment suppress: box memory, merged flags,
// indexes and the pipelined pair test
// depends on bcs_pkg
`default_nettype none
module bcs_dp #(
   parameter int MAX_BOXES = bcs_pkg::MAX_BOXES
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire bcs_pkg::box_in_type               req_data,
   input  wire logic [bcs_pkg::THR_BITS-1:0]      merge_threshold,
   input  wire bcs_pkg::cmd_type                  cmd,
   output bcs_pkg::status_type                    status,
   output logic                                   rsp_valid,
   output bcs_pkg::box_out_type                   rsp_data
);

   localparam int C       = bcs_pkg::COORD_BITS;
   localparam int TW      = bcs_pkg::THR_BITS;
   localparam int CNT_W   = $clog2(MAX_BOXES + 1);
   localparam int IDX_W   = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
   localparam int BOX_W   = 4 * C;
   localparam int SUM_W   = C + 1;
   localparam int AREA_W  = 2 * C;
   localparam int INTER_W = 2 * SUM_W;
   localparam int PROD_W  = AREA_W + TW;
   localparam int CMP_W   = INTER_W + 8;

   logic [BOX_W-1:0]     mem [MAX_BOXES];
   logic [BOX_W-1:0]     rd_a_ff, rd_b_ff;
   logic [CNT_W-1:0]     count_ff, i_ff, j_ff, last_ff;
   logic [MAX_BOXES-1:0] merged_ff;
   logic [4:0]           v_ff;

   logic                 ovl1_ff, ovl2_ff, ovl3_ff;
   logic [SUM_W-1:0]     iw_ff, ih_ff;
   logic [AREA_W-1:0]    area_a_ff, area_b_ff, min_ff;
   logic [INTER_W-1:0]   inter_ff, inter3_ff;
   logic                 ge2_ff, ge3_ff, ge4_ff, hit_ff;
   logic [PROD_W-1:0]    prod_ff;

   logic                 rsp_valid_ff;
   bcs_pkg::box_out_type rsp_data_ff;

   logic [C-1:0]         ax, ay, aw, ah, bx, by, bw, bh;
   logic [C-1:0]         l_x, t_y;
   logic [SUM_W-1:0]     ar, ab, br, bb, r_x, b_y;

   // box memory, one write port and two registered read ports
   always_ff @(posedge clock) begin
      if (cmd.load && (count_ff < CNT_W'(MAX_BOXES))) begin
         mem[count_ff[IDX_W-1:0]] <= {req_data.box_x, req_data.box_y,
                                      req_data.box_width, req_data.box_height};
      end
      rd_a_ff <= mem[i_ff[IDX_W-1:0]];
      rd_b_ff <= mem[j_ff[IDX_W-1:0]];
   end

   // counters, merged flags and pipeline valids
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         i_ff      <= '0;
         j_ff      <= '0;
         last_ff   <= '0;
         merged_ff <= '0;
         v_ff      <= '0;
      end else begin
         v_ff <= {v_ff[3:0], cmd.pair_go};
         if (cmd.load && (count_ff < CNT_W'(MAX_BOXES))) begin
            count_ff <= count_ff + 1'b1;
         end
         if (cmd.merge_i) begin
            merged_ff[i_ff[IDX_W-1:0]] <= 1'b1;
         end
         if (cmd.merge_j) begin
            merged_ff[j_ff[IDX_W-1:0]] <= 1'b1;
         end
         if (cmd.i_clr) begin
            i_ff <= '0;
         end else if (cmd.i_inc) begin
            i_ff <= i_ff + 1'b1;
         end
         if (cmd.j_from_i) begin
            j_ff <= i_ff + 1'b1;
         end else if (cmd.j_inc) begin
            j_ff <= j_ff + 1'b1;
         end
         if (cmd.note_last) begin
            last_ff <= i_ff;
         end
         if (cmd.clear_set) begin
            count_ff  <= '0;
            merged_ff <= '0;
         end
      end
   end

   // pair geometry from the read words
   always_comb begin
      {ax, ay, aw, ah} = rd_a_ff;
      {bx, by, bw, bh} = rd_b_ff;
      ar  = SUM_W'(ax) + SUM_W'(aw);
      ab  = SUM_W'(ay) + SUM_W'(ah);
      br  = SUM_W'(bx) + SUM_W'(bw);
      bb  = SUM_W'(by) + SUM_W'(bh);
      l_x = (ax > bx) ? ax : bx;
      t_y = (ay > by) ? ay : by;
      r_x = (ar < br) ? ar : br;
      b_y = (ab < bb) ? ab : bb;
   end

   // pair test pipeline: geometry, intersection, threshold product, compare
   always_ff @(posedge clock) begin
      ovl1_ff   <= (SUM_W'(l_x) < r_x) && (SUM_W'(t_y) < b_y);
      iw_ff     <= r_x - SUM_W'(l_x);
      ih_ff     <= b_y - SUM_W'(t_y);
      area_a_ff <= AREA_W'(aw) * AREA_W'(ah);
      area_b_ff <= AREA_W'(bw) * AREA_W'(bh);

      ovl2_ff  <= ovl1_ff;
      inter_ff <= INTER_W'(iw_ff) * INTER_W'(ih_ff);
      ge2_ff   <= area_a_ff >= area_b_ff;
      min_ff   <= (area_a_ff >= area_b_ff) ? area_b_ff : area_a_ff;

      ovl3_ff   <= ovl2_ff;
      inter3_ff <= inter_ff;
      ge3_ff    <= ge2_ff;
      prod_ff   <= PROD_W'(merge_threshold) * PROD_W'(min_ff);

      ge4_ff <= ge3_ff;
      hit_ff <= ovl3_ff ? ({inter3_ff, 8'd0} >= CMP_W'(prod_ff))
                        : (merge_threshold == '0);
   end

   // status to the controller
   always_comb begin
      status.i_end     = i_ff >= count_ff;
      status.i_merged  = merged_ff[i_ff[IDX_W-1:0]];
      status.j_end     = j_ff >= count_ff;
      status.j_merged  = merged_ff[j_ff[IDX_W-1:0]];
      status.pair_done = v_ff[4];
      status.hit       = hit_ff;
      status.i_wins    = ge4_ff;
   end

   // output word register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.emit;
      end
      rsp_data_ff.kept_x      <= rd_a_ff[4*C-1:3*C];
      rsp_data_ff.kept_y      <= rd_a_ff[3*C-1:2*C];
      rsp_data_ff.kept_width  <= rd_a_ff[2*C-1:C];
      rsp_data_ff.kept_height <= rd_a_ff[C-1:0];
      rsp_data_ff.last_kept   <= i_ff == last_ff;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire

@@ hw/rtl/box_containment_suppress.sv @@
// top level of box containment suppress: threshold register, controller, datapath
// depends on bcs_pkg, bcs_ctrl, bcs_dp
//
//  channel   handshake            word
//  input     start / busy         req_data  (box_in_type)
//  result    rsp_valid strobe     rsp_data  (box_out_type)
//  config    psel/penable/pwrite  pwdata -> merge threshold at paddr 0
//
// a box is taken as start is accepted; one without last_box finishes there
// the closing box starts the pairwise pass, paced by the single pair unit: each outer
// box is skipped if merged, else it opens an inner run in which each pair is skipped
// if merged, else tested (memory read, four test stages, decision); then a survivor
// scan over all boxes, an output pass that emits the survivors, and a finish step
// synchronous reset clears the controller, box count and merged flags
// results are one-cycle strobes; the receiver cannot stall
`default_nettype none
module box_containment_suppress #(
   parameter int MAX_BOXES = bcs_pkg::MAX_BOXES
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire bcs_pkg::box_in_type                 req_data,
   output logic                                     rsp_valid,
   output bcs_pkg::box_out_type                     rsp_data,
   input  wire logic                                psel,
   input  wire logic                                penable,
   input  wire logic                                pwrite,
   input  wire logic [bcs_pkg::CSR_ADDR_W-1:0]      paddr,
   input  wire logic [bcs_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [bcs_pkg::CSR_DATA_W-1:0]           prdata,
   output logic                                     pready
);

   logic [bcs_pkg::THR_BITS-1:0] thr_ff;
   logic                         busy_int;
   logic                         accept;
   bcs_pkg::cmd_type             cmd;
   bcs_pkg::status_type          status;

   // threshold register
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= bcs_pkg::THR_RESET;
      end else if (psel && penable && pwrite
                   && (paddr[2] == bcs_pkg::REG_MERGE_THRESHOLD)) begin
         thr_ff <= pwdata[bcs_pkg::THR_BITS-1:0];
      end
   end

   // register read
   always_comb begin
      prdata = '0;
      if (paddr[2] == bcs_pkg::REG_MERGE_THRESHOLD) begin
         prdata = bcs_pkg::CSR_DATA_W'(thr_ff);
      end
   end

   assign pready = 1'b1;
   assign accept = start && !busy_int;
   assign busy   = busy_int;

   bcs_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (accept),
      .last_box (req_data.last_box),
      .status   (status),
      .busy     (busy_int),
      .cmd      (cmd)
   );

   bcs_dp #(
      .MAX_BOXES (MAX_BOXES)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_data        (req_data),
      .merge_threshold (thr_ff),
      .cmd             (cmd),
      .status          (status),
      .rsp_valid       (rsp_valid),
      .rsp_data        (rsp_data)
   );

endmodule
`default_nettype wire

@@ tb/box_containment_suppress_tb.sv @@
// testbench for box_containment_suppress: directed and random box sets, checked
// against a predictor held in a small scoreboard class
// depends on bcs_pkg and box_containment_suppress
`default_nettype none
module box_containment_suppress_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // predictor of the suppression pass and store of expected survivors
   class survivor_board;
      bit [bcs_pkg::THR_BITS-1:0] merge_thr = bcs_pkg::THR_RESET;
      bcs_pkg::box_in_type        boxes[bcs_pkg::MAX_BOXES];
      bit                         merged[bcs_pkg::MAX_BOXES];
      int                         count = 0;
      bcs_pkg::box_out_type       survivors[$];
      int                         errors = 0;

      function longint unsigned area(int k);
         return longint'(boxes[k].box_width) * longint'(boxes[k].box_height);
      endfunction

      function bit pair_hits(int a, int b);
         longint unsigned l, r, t, btm, inter, min_area;
         l   = (boxes[a].box_x > boxes[b].box_x) ? boxes[a].box_x : boxes[b].box_x;
         r   = longint'(boxes[a].box_x) + boxes[a].box_width;
         if (longint'(boxes[b].box_x) + boxes[b].box_width < r)
            r = longint'(boxes[b].box_x) + boxes[b].box_width;
         t   = (boxes[a].box_y > boxes[b].box_y) ? boxes[a].box_y : boxes[b].box_y;
         btm = longint'(boxes[a].box_y) + boxes[a].box_height;
         if (longint'(boxes[b].box_y) + boxes[b].box_height < btm)
            btm = longint'(boxes[b].box_y) + boxes[b].box_height;
         if (!(l < r && t < btm)) return merge_thr == 0;
         inter    = (r - l) * (btm - t);
         min_area = (area(a) >= area(b)) ? area(b) : area(a);
         return (inter << 8) >= longint'(merge_thr) * min_area;
      endfunction

      // note an accepted box; the closing box runs the pass
      function void note_box(bcs_pkg::box_in_type b);
         int last_idx;
         bcs_pkg::box_out_type o;
         last_idx = -1;
         if (count < bcs_pkg::MAX_BOXES) begin
            boxes[count] = b;
            merged[count] = 0;
            count++;
         end
         if (!b.last_box) return;
         for (int i = 0; i < count; i++) begin
            if (merged[i]) continue;
            for (int j = i + 1; j < count; j++) begin
               if (merged[j]) continue;
               if (pair_hits(i, j)) begin
                  if (area(i) >= area(j)) merged[j] = 1;
                  else begin
                     merged[i] = 1;
                     break;
                  end
               end
            end
         end
         for (int i = 0; i < count; i++) if (!merged[i]) last_idx = i;
         for (int i = 0; i < count; i++) begin
            if (merged[i]) continue;
            o.kept_x      = boxes[i].box_x;
            o.kept_y      = boxes[i].box_y;
            o.kept_width  = boxes[i].box_width;
            o.kept_height = boxes[i].box_height;
            o.last_kept   = (i == last_idx);
            survivors = {survivors, o};
         end
         count = 0;
      endfunction

      function void check_word(bcs_pkg::box_out_type got);
         bcs_pkg::box_out_type exp_w;
         if (survivors.size() == 0) begin
            errors++;
            $error("unexpected result word %h", got);
            return;
         end
         exp_w = survivors.pop_front();
         if (got.kept_x != exp_w.kept_x) begin
            errors++;
            $error("kept_x expected %0d actual %0d", exp_w.kept_x, got.kept_x);
         end
         if (got.kept_y != exp_w.kept_y) begin
            errors++;
            $error("kept_y expected %0d actual %0d", exp_w.kept_y, got.kept_y);
         end
         if (got.kept_width != exp_w.kept_width) begin
            errors++;
            $error("kept_width expected %0d actual %0d", exp_w.kept_width, got.kept_width);
         end
         if (got.kept_height != exp_w.kept_height) begin
            errors++;
            $error("kept_height expected %0d actual %0d", exp_w.kept_height,
                   got.kept_height);
         end
         if (got.last_kept != exp_w.last_kept) begin
            errors++;
            $error("last_kept expected %0d actual %0d", exp_w.last_kept, got.last_kept);
         end
      endfunction
   endclass

   logic                           clock = 0;
   logic                           reset = 1;
   logic                           start = 0;
   logic                           busy;
   bcs_pkg::box_in_type            req_data = '0;
   logic                           rsp_valid;
   bcs_pkg::box_out_type           rsp_data;
   logic                           psel = 0;
   logic                           penable = 0;
   logic                           pwrite = 0;
   logic [bcs_pkg::CSR_ADDR_W-1:0] paddr = '0;
   logic [bcs_pkg::CSR_DATA_W-1:0] pwdata = '0;
   logic [bcs_pkg::CSR_DATA_W-1:0] prdata;
   logic                           pready;

   survivor_board board = new();
   bit                             no_gaps = 0;

   box_containment_suppress uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #6 clock = ~clock;

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid) board.check_word(rsp_data);
   end

   // send one box word, sometimes with start held low first, and wait while busy
   task send_box(input bcs_pkg::box_in_type b);
      if (!no_gaps && $urandom_range(99) < 22) begin
         start <= 0;
         @(posedge clock);
      end
      start    <= 1;
      req_data <= b;
      @(posedge clock);
      while (busy) @(posedge clock);
      board.note_box(b);
   endtask

   task send_xywh(input int x, y, w, h, input bit last);
      bcs_pkg::box_in_type b;
      b.box_x      = bcs_pkg::COORD_BITS'(x);
      b.box_y      = bcs_pkg::COORD_BITS'(y);
      b.box_width  = bcs_pkg::COORD_BITS'(w);
      b.box_height = bcs_pkg::COORD_BITS'(h);
      b.last_box   = last;
      send_box(b);
   endtask

   // hold off until every expected survivor has come and the block is idle
   task drain;
      start <= 0;
      @(posedge clock);
      while (board.survivors.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task write_threshold(input int value);
      drain();
      psel    <= 1;
      pwrite  <= 1;
      penable <= 0;
      paddr   <= bcs_pkg::CSR_ADDR_W'(bcs_pkg::REG_MERGE_THRESHOLD) << 2;
      pwdata  <= bcs_pkg::CSR_DATA_W'(value);
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      psel    <= 0;
      penable <= 0;
      pwrite  <= 0;
      board.merge_thr = bcs_pkg::THR_BITS'(value);
   endtask

   function bcs_pkg::box_in_type rand_box(input bit last);
      bcs_pkg::box_in_type b;
      if ($urandom_range(7) == 0) begin
         b.box_x      = bcs_pkg::COORD_BITS'($urandom);
         b.box_y      = bcs_pkg::COORD_BITS'($urandom);
         b.box_width  = bcs_pkg::COORD_BITS'($urandom);
         b.box_height = bcs_pkg::COORD_BITS'($urandom);
      end else begin
         b.box_x      = bcs_pkg::COORD_BITS'($urandom_range(0, 200));
         b.box_y      = bcs_pkg::COORD_BITS'($urandom_range(0, 200));
         b.box_width  = bcs_pkg::COORD_BITS'($urandom_range(0, 160));
         b.box_height = bcs_pkg::COORD_BITS'($urandom_range(0, 160));
      end
      b.last_box = last;
      return b;
   endfunction

   // random sets of one to eight boxes each
   task random_sets(input int n_boxes);
      int sent, size;
      sent = 0;
      while (sent < n_boxes) begin
         size = $urandom_range(1, 8);
         for (int k = 0; k < size; k++) send_box(rand_box(k == size - 1));
         sent += size;
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: extremes, containment, tie, zero size, touching edges
      send_xywh(4095, 4095, 4095, 4095, 1);
      send_xywh(0, 0, 100, 100, 0);
      send_xywh(10, 10, 50, 50, 0);
      send_xywh(200, 200, 0, 50, 0);
      send_xywh(100, 0, 100, 100, 0);
      send_xywh(0, 0, 100, 100, 1);
      // earlier box is the smaller one and loses
      send_xywh(0, 0, 10, 10, 0);
      send_xywh(0, 0, 100, 100, 0);
      send_xywh(500, 500, 20, 20, 1);
      // threshold zero merges disjoint boxes
      write_threshold(0);
      send_xywh(0, 0, 10, 10, 0);
      send_xywh(3000, 3000, 10, 10, 0);
      send_xywh(0, 0, 0, 0, 1);
      // full ratio only for full containment
      write_threshold(256);
      send_xywh(20, 20, 30, 30, 0);
      send_xywh(20, 20, 30, 30, 0);
      send_xywh(25, 25, 30, 30, 1);
      // threshold above one never reached by an overlap
      write_threshold(511);
      send_xywh(5, 5, 40, 40, 0);
      send_xywh(5, 5, 40, 40, 0);
      send_xywh(4000, 0, 95, 4095, 1);

      // random phases over several thresholds
      write_threshold(192);
      random_sets(10);
      write_threshold($urandom_range(1, 255));
      random_sets(6);
      write_threshold(128);
      // overfull set back to back: last two boxes dropped, the closing one ends it
      no_gaps = 1;
      for (int k = 0; k < bcs_pkg::MAX_BOXES + 2; k++)
         send_xywh((k % 8) * 500, (k / 8) * 500, $urandom_range(1, 400),
                   $urandom_range(1, 400), k == bcs_pkg::MAX_BOXES + 1);
      no_gaps = 0;
      write_threshold($urandom_range(0, 256));
      random_sets(5);
      write_threshold(64);
      random_sets(5);

      drain();
      if (board.errors == 0)
         $display("box_containment_suppress regression: pass");
      else
         $display("box_containment_suppress regression: fail");
      $finish;
   end

   // watchdog
   initial begin
      #10ms;
      $display("box_containment_suppress regression: fail");
      $finish;
   end
endmodule
`default_nettype wire

@@ filelist.f @@
hw/rtl/bcs_pkg.sv
hw/rtl/bcs_ctrl.sv
hw/rtl/bcs_dp.sv
hw/rtl/box_containment_suppress.sv
tb/box_containment_suppress_tb.sv
